### hw/rtl/tcxf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcxf_pkg
// shared types and constants of the tftp client transfer controller
// ----------------------------------------------------------------------------
package tcxf_pkg;

  localparam int unsigned BlockBytesDefault = 512;
  localparam int unsigned HeaderBytes       = 4;
  localparam int unsigned CntW              = 10;
  localparam int unsigned FieldW            = 16;
  localparam int unsigned InDataW           = 96;
  localparam int unsigned OutDataW          = 56;

  localparam logic [FieldW-1:0] OpcodeData  = 16'd3;
  localparam logic [FieldW-1:0] OpcodeAck   = 16'd4;
  localparam logic [FieldW-1:0] OpcodeError = 16'd5;

  localparam logic [FieldW-1:0] ErrUnknownTid = 16'd5;
  localparam logic [FieldW-1:0] ErrLastCode   = 16'd7;

  typedef enum logic [1:0] {
    OPK_OTHER = 2'd0,
    OPK_DATA  = 2'd1,
    OPK_ACK   = 2'd2,
    OPK_ERROR = 2'd3
  } op_kind_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_ACK      = 2'd1,
    KIND_DATA     = 2'd2,
    KIND_DISKFULL = 2'd3
  } reply_kind_e;

  typedef enum logic [2:0] {
    OUT_IGNORED  = 3'd0,
    OUT_REPLIED  = 3'd1,
    OUT_COMPLETE = 3'd2,
    OUT_FATAL    = 3'd3,
    OUT_NONFATAL = 3'd4
  } outcome_e;

  // classified packet handed from front to back
  typedef struct packed {
    op_kind_e            op;
    logic [FieldW-1:0]   blk;
    logic                blk_zero;
    logic                blk_one;
    logic                last;
    logic [FieldW-1:0]   port;
    logic                fatal;
    logic                write_ok;
    logic [CntW-1:0]     cnt_sat;
    logic                cnt_short;
  } pkt_t;

endpackage
`default_nettype wire

### hw/rtl/tcxf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcxf_front
// accepts packet headers and classifies them into a registered descriptor
// ----------------------------------------------------------------------------
module tcxf_front #(
  parameter int unsigned BLOCK_BYTES = tcxf_pkg::BlockBytesDefault
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   valid_i,
  output logic                                        ready_o,
  input  wire logic [tcxf_pkg::FieldW-1:0]            opcode_i,
  input  wire logic [tcxf_pkg::FieldW-1:0]            block_i,
  input  wire logic [tcxf_pkg::FieldW-1:0]            bytes_i,
  input  wire logic [tcxf_pkg::FieldW-1:0]            port_i,
  input  wire logic [tcxf_pkg::FieldW-1:0]            code_i,
  input  wire logic                                   write_ok_i,
  input  wire logic [tcxf_pkg::CntW-1:0]              cnt_i,
  output logic                                        valid_o,
  input  wire logic                                   ready_i,
  output tcxf_pkg::pkt_t                              pkt_o
);

  localparam int unsigned CmpW = tcxf_pkg::FieldW + 1;
  localparam logic [CmpW-1:0] BlockBytesC = CmpW'(BLOCK_BYTES);
  localparam logic [CmpW-1:0] HeaderC     = CmpW'(tcxf_pkg::HeaderBytes);

  logic            vld_q, vld_d;
  tcxf_pkg::pkt_t  pkt_q, pkt_d;
  logic [CmpW-1:0] bytes_ext;
  logic [CmpW-1:0] cnt_ext;
  logic            take;

  assign ready_o   = !vld_q || ready_i;
  assign take      = valid_i && ready_o;
  assign bytes_ext = {1'b0, bytes_i};
  assign cnt_ext   = CmpW'(cnt_i);

  always_comb begin
    pkt_d.op = tcxf_pkg::OPK_OTHER;
    unique case (opcode_i)
      tcxf_pkg::OpcodeData:  pkt_d.op = tcxf_pkg::OPK_DATA;
      tcxf_pkg::OpcodeAck:   pkt_d.op = tcxf_pkg::OPK_ACK;
      tcxf_pkg::OpcodeError: pkt_d.op = tcxf_pkg::OPK_ERROR;
      default:               pkt_d.op = tcxf_pkg::OPK_OTHER;
    endcase
    pkt_d.blk       = block_i;
    pkt_d.blk_zero  = (block_i == '0);
    pkt_d.blk_one   = (block_i == tcxf_pkg::FieldW'(1));
    pkt_d.last      = (bytes_ext >= HeaderC) && ((bytes_ext - HeaderC) < BlockBytesC);
    pkt_d.port      = port_i;
    pkt_d.fatal     = (code_i <= tcxf_pkg::ErrLastCode) && (code_i != tcxf_pkg::ErrUnknownTid);
    pkt_d.write_ok  = write_ok_i;
    pkt_d.cnt_short = (cnt_ext < BlockBytesC);
    pkt_d.cnt_sat   = (cnt_ext > BlockBytesC) ? BlockBytesC[tcxf_pkg::CntW-1:0] : cnt_i;
  end

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pkt_q <= pkt_d;
    end
  end

  assign valid_o = vld_q;
  assign pkt_o   = pkt_q;

endmodule
`default_nettype wire

### hw/rtl/tcxf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcxf_queue
// two-entry queue of classified packets between front and back
// ----------------------------------------------------------------------------
module tcxf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  tcxf_pkg::pkt_t      pkt_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output tcxf_pkg::pkt_t      pkt_o
);

  tcxf_pkg::pkt_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign pkt_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= pkt_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/tcxf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcxf_back
// transfer state machine and registered reply word
// ----------------------------------------------------------------------------
module tcxf_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  output logic                                 ready_o,
  input  tcxf_pkg::pkt_t                       pkt_i,
  output logic                                 valid_o,
  input  wire logic                            ready_i,
  output logic [1:0]                           reply_kind_o,
  output logic [tcxf_pkg::FieldW-1:0]          reply_block_o,
  output logic [tcxf_pkg::CntW-1:0]            reply_data_bytes_o,
  output logic [tcxf_pkg::FieldW-1:0]          reply_port_o,
  output logic [2:0]                           outcome_o,
  output logic                                 transfer_done_o,
  output logic [1:0]                           phase_now_o
);

  typedef enum logic [1:0] {
    PH_INIT  = 2'd0,
    PH_READ  = 2'd1,
    PH_WRITE = 2'd2,
    PH_FINAL = 2'd3
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [tcxf_pkg::FieldW-1:0] exp_q, exp_d;
  logic                        done_q, done_d;
  logic                        out_vld_q;

  tcxf_pkg::reply_kind_e       kind_d;
  logic [tcxf_pkg::FieldW-1:0] blk_d;
  logic [tcxf_pkg::CntW-1:0]   bytes_d;
  logic [tcxf_pkg::FieldW-1:0] port_d;
  tcxf_pkg::outcome_e          outc_d;

  logic                        do_data, do_chunk, do_error;
  logic [tcxf_pkg::FieldW-1:0] blk_inc, exp_dec, exp_inc;
  logic                        take;

  assign ready_o = !out_vld_q || ready_i;
  assign take    = valid_i && ready_o;
  assign blk_inc = pkt_i.blk + tcxf_pkg::FieldW'(1);
  assign exp_dec = exp_q - tcxf_pkg::FieldW'(1);
  assign exp_inc = exp_q + tcxf_pkg::FieldW'(1);

  always_comb begin
    do_data  = 1'b0;
    do_chunk = 1'b0;
    do_error = 1'b0;
    kind_d   = tcxf_pkg::KIND_NONE;
    blk_d    = '0;
    bytes_d  = '0;
    port_d   = '0;
    outc_d   = tcxf_pkg::OUT_IGNORED;
    phase_d  = phase_q;
    exp_d    = exp_q;
    done_d   = done_q;

    unique case (phase_q)
      PH_INIT: begin
        if (pkt_i.op == tcxf_pkg::OPK_DATA && pkt_i.blk_one) begin
          do_data = 1'b1;
          phase_d = PH_READ;
        end else if (pkt_i.op == tcxf_pkg::OPK_ACK && pkt_i.blk_zero) begin
          do_chunk = 1'b1;
        end else if (pkt_i.op == tcxf_pkg::OPK_ERROR) begin
          do_error = 1'b1;
        end
      end
      PH_READ: begin
        if (pkt_i.op == tcxf_pkg::OPK_DATA && pkt_i.blk == exp_q) begin
          do_data = 1'b1;
        end else if (pkt_i.op == tcxf_pkg::OPK_ERROR) begin
          do_error = 1'b1;
        end
      end
      PH_WRITE: begin
        if (pkt_i.op == tcxf_pkg::OPK_ACK && blk_inc == exp_q) begin
          do_chunk = 1'b1;
        end else if (pkt_i.op == tcxf_pkg::OPK_ERROR) begin
          do_error = 1'b1;
        end
      end
      PH_FINAL: begin
        if (pkt_i.op == tcxf_pkg::OPK_ACK && pkt_i.blk == exp_dec) begin
          done_d = 1'b1;
          outc_d = tcxf_pkg::OUT_COMPLETE;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    if (do_data) begin
      outc_d = tcxf_pkg::OUT_REPLIED;
      port_d = pkt_i.port;
      if (!pkt_i.write_ok && !done_q) begin
        kind_d = tcxf_pkg::KIND_DISKFULL;
        done_d = 1'b1;
      end else begin
        if (pkt_i.last) begin
          done_d = 1'b1;
        end
        kind_d = tcxf_pkg::KIND_ACK;
        blk_d  = exp_q;
        exp_d  = exp_inc;
      end
    end

    if (do_chunk) begin
      outc_d  = tcxf_pkg::OUT_REPLIED;
      kind_d  = tcxf_pkg::KIND_DATA;
      port_d  = pkt_i.port;
      blk_d   = exp_q;
      bytes_d = pkt_i.cnt_sat;
      exp_d   = exp_inc;
      phase_d = pkt_i.cnt_short ? PH_FINAL : PH_WRITE;
    end

    if (do_error) begin
      outc_d = pkt_i.fatal ? tcxf_pkg::OUT_FATAL : tcxf_pkg::OUT_NONFATAL;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q            <= PH_INIT;
      exp_q              <= tcxf_pkg::FieldW'(1);
      done_q             <= 1'b0;
      out_vld_q          <= 1'b0;
      reply_kind_o       <= '0;
      reply_block_o      <= '0;
      reply_data_bytes_o <= '0;
      reply_port_o       <= '0;
      outcome_o          <= '0;
      transfer_done_o    <= 1'b0;
      phase_now_o        <= '0;
    end else begin
      if (take) begin
        phase_q            <= phase_d;
        exp_q              <= exp_d;
        done_q             <= done_d;
        out_vld_q          <= 1'b1;
        reply_kind_o       <= kind_d;
        reply_block_o      <= blk_d;
        reply_data_bytes_o <= bytes_d;
        reply_port_o       <= port_d;
        outcome_o          <= outc_d;
        transfer_done_o    <= done_d;
        phase_now_o        <= phase_d;
      end else if (ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign valid_o = out_vld_q;

endmodule
`default_nettype wire

### hw/rtl/tftp_client_transfer_fsm_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tftp_client_transfer_fsm_unit
// client side tftp transfer controller: one reply word per received header
// path: header word registered in front, held in the queue, reply word registered in back
// throughput: one word per cycle unless the reply output stalls, set by the state update in back
// front register and a two-entry queue let input and output stall separately
// reset: phase init, expected block one, done clear, all stages empty
// ----------------------------------------------------------------------------
module tftp_client_transfer_fsm_unit #(
  parameter int unsigned BLOCK_BYTES = tcxf_pkg::BlockBytesDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // packet_opcode, packet_block, packet_bytes, source_port, peer_error_code,
  // store_write_ok, chunk_read_count, zero fill
  input  wire logic [tcxf_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // reply_kind, reply_block, reply_data_bytes, reply_port, outcome,
  // transfer_done, phase_now, zero fill
  output logic [tcxf_pkg::OutDataW-1:0]          m_axis_tdata
);

  logic                        fr_valid, fr_ready;
  tcxf_pkg::pkt_t              fr_pkt;
  logic                        q_valid, q_ready;
  tcxf_pkg::pkt_t              q_pkt;

  logic [1:0]                  reply_kind;
  logic [tcxf_pkg::FieldW-1:0] reply_block;
  logic [tcxf_pkg::CntW-1:0]   reply_data_bytes;
  logic [tcxf_pkg::FieldW-1:0] reply_port;
  logic [2:0]                  outcome;
  logic                        transfer_done;
  logic [1:0]                  phase_now;

  tcxf_front #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .opcode_i   (s_axis_tdata[15:0]),
    .block_i    (s_axis_tdata[31:16]),
    .bytes_i    (s_axis_tdata[47:32]),
    .port_i     (s_axis_tdata[63:48]),
    .code_i     (s_axis_tdata[79:64]),
    .write_ok_i (s_axis_tdata[80]),
    .cnt_i      (s_axis_tdata[90:81]),
    .valid_o    (fr_valid),
    .ready_i    (fr_ready),
    .pkt_o      (fr_pkt)
  );

  tcxf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .pkt_i   (fr_pkt),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .pkt_o   (q_pkt)
  );

  tcxf_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (q_valid),
    .ready_o            (q_ready),
    .pkt_i              (q_pkt),
    .valid_o            (m_axis_tvalid),
    .ready_i            (m_axis_tready),
    .reply_kind_o       (reply_kind),
    .reply_block_o      (reply_block),
    .reply_data_bytes_o (reply_data_bytes),
    .reply_port_o       (reply_port),
    .outcome_o          (outcome),
    .transfer_done_o    (transfer_done),
    .phase_now_o        (phase_now)
  );

  assign m_axis_tdata = {6'b0, phase_now, transfer_done, outcome, reply_port,
                         reply_data_bytes, reply_block, reply_kind};

endmodule
`default_nettype wire

### hw/rtl/tcxf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcxf_checker
// port-level checks of the tftp client transfer controller
// ----------------------------------------------------------------------------
module tcxf_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [tcxf_pkg::InDataW-1:0]      s_axis_tdata,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [tcxf_pkg::OutDataW-1:0]     m_axis_tdata
);

  logic [1:0]                  kind;
  logic [tcxf_pkg::CntW-1:0]   nbytes;
  logic [tcxf_pkg::FieldW-1:0] rport;
  logic [2:0]                  outc;
  logic                        done;
  logic                        in_word;

  assign kind    = m_axis_tdata[1:0];
  assign nbytes  = m_axis_tdata[27:18];
  assign rport   = m_axis_tdata[43:28];
  assign outc    = m_axis_tdata[46:44];
  assign done    = m_axis_tdata[47];
  assign in_word = s_axis_tvalid && s_axis_tready && (s_axis_tdata[95:91] == '0);

  // stalled reply word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("reply word changed while stalled");

  // no reply means no port and no length
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind == tcxf_pkg::KIND_NONE |-> rport == '0 && nbytes == '0)
    else $error("empty reply carries port or length");

  // a replied outcome always carries a reply kind
  a_replied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && outc == tcxf_pkg::OUT_REPLIED |-> kind != tcxf_pkg::KIND_NONE)
    else $error("replied outcome without reply");

  // completion, peer errors and a disk-full reply leave the transfer done
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (outc == tcxf_pkg::OUT_COMPLETE || outc == tcxf_pkg::OUT_FATAL ||
                      outc == tcxf_pkg::OUT_NONFATAL || kind == tcxf_pkg::KIND_DISKFULL)
    |-> done)
    else $error("terminal outcome without done");

  // no reply word appears the cycle right after an idle empty pipeline accepts
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_word && !m_axis_tvalid && $past(!s_axis_tvalid, 1) && $past(!s_axis_tvalid, 2)
    && $past(!m_axis_tvalid, 1) |=> !m_axis_tvalid)
    else $error("reply word appeared too early");

endmodule

bind tftp_client_transfer_fsm_unit tcxf_checker u_tcxf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
